FILE: design/sixteen_bit_isa_instruction_step_macros.svh
// assertion macros for the instruction step core
// used by the top level only
`ifndef SIXTEEN_BIT_ISA_INSTRUCTION_STEP_MACROS_SVH
`define SIXTEEN_BIT_ISA_INSTRUCTION_STEP_MACROS_SVH
`define SBI_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) else $error("lbl");
`define SBI_ASSERT_NEXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) else $error("lbl");
`endif

FILE: design/sbi_pkg.sv
// types and constants for the instruction step core
// no dependencies
`timescale 1ns / 1ps
package sbi_pkg;
  localparam logic [15:0] PcReset = 16'h8200;
  localparam logic [2:0] NzpZero = 3'b010;
  localparam logic [3:0] OpBr = 4'h0, OpArith = 4'h1, OpCmp = 4'h2, OpJsr = 4'h4,
    OpLogic = 4'h5, OpLdr = 4'h6, OpStr = 4'h7, OpRti = 4'h8, OpConst = 4'h9,
    OpShift = 4'hA, OpJmp = 4'hC, OpHiconst = 4'hD, OpTrap = 4'hF;
  localparam logic [2:0] StOk = 3'd0, StBadAddr = 3'd1, StPriv = 3'd2,
    StIllegal = 3'd3, StLoaded = 3'd4;

  typedef struct packed {
    logic cmd;
    logic [15:0] load_addr;
    logic [15:0] load_data;
  } req_t;

  typedef struct packed {
    logic [15:0] pc_now;
    logic [15:0] instr_word;
    logic reg_we;
    logic [2:0] reg_dest;
    logic [15:0] reg_value;
    logic nzp_we;
    logic [2:0] nzp_value;
    logic data_we;
    logic [15:0] dmem_addr;
    logic [15:0] dmem_value;
    logic [2:0] status;
  } rsp_t;

  typedef struct packed {
    logic clear;
    logic mem_load;
    logic fetch;
    logic exec;
    logic div_start;
    logic data_rd;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic is_load;
    logic need_div;
    logic div_busy;
    logic need_mem;
  } sts_t;
endpackage

FILE: design/sbi_div.sv
// iterative 16-bit unsigned divider, one quotient bit per cycle
// depends on nothing
`timescale 1ns / 1ps
module sbi_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic        busy_o,
  output logic [15:0] quot_o,
  output logic [15:0] rem_o
);
  logic [4:0] cnt_q, cnt_d;
  logic [15:0] q_q, q_d, r_q, r_d, dv_q, dv_d;
  logic [16:0] trial;
  assign trial = {r_q, q_q[15]} - {1'b0, dv_q};
  always_comb begin
    cnt_d = cnt_q; q_d = q_q; r_d = r_q; dv_d = dv_q;
    if (start_i) begin
      cnt_d = 5'd16; q_d = dividend_i; r_d = '0; dv_d = divisor_i;
    end else if (cnt_q != 5'd0) begin
      cnt_d = cnt_q - 5'd1;
      if (!trial[16]) begin
        r_d = trial[15:0]; q_d = {q_q[14:0], 1'b1};
      end else begin
        r_d = {r_q[14:0], q_q[15]}; q_d = {q_q[14:0], 1'b0};
      end
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else cnt_q <= cnt_d;
  end
  always_ff @(posedge clk_i) begin
    q_q <= q_d; r_q <= r_d; dv_q <= dv_d;
  end
  assign busy_o = (cnt_q != 5'd0);
  assign quot_o = (dv_q == 16'd0) ? 16'd0 : q_q;
  assign rem_o  = (dv_q == 16'd0) ? 16'd0 : r_q;
endmodule

FILE: design/sbi_datapath.sv
// datapath: memory, register file, pc, flags and execute logic
// depends on sbi_pkg and sbi_div
`timescale 1ns / 1ps
module sbi_datapath #(
  parameter int AddrW = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sbi_pkg::req_t  req_i,
  input  sbi_pkg::cmd_t  cmd_i,
  output sbi_pkg::sts_t  sts_o,
  output sbi_pkg::rsp_t  rsp_o
);
  logic [15:0] mem [2**AddrW];
  logic [15:0] rf_q [8];
  logic [AddrW-1:0] clr_q, clr_d;
  logic [15:0] pc_q, ir_q, rdata_q, next_q, val_q, addr_q, dval_q;
  logic [15:0] next_d, val_d, addr_d, dval_d;
  logic priv_q;
  logic [2:0] nzp_q, d_q, st_q, cmpn_q;
  logic [2:0] d_d, st_d, cmpn_d;
  logic rwe_q, nwe_q, dwe_q, ismem_q, isdiv_q, ismod_q;
  logic rwe_d, nwe_d, dwe_d, ismem_d, isdiv_d, ismod_d;
  logic [15:0] rsv, rtv, rdv, sx5, sx6, sx7, sx9, sx11, pc1, quot, rem, ldv, ea;
  logic [3:0] op;
  logic [2:0] d, s, t;
  logic [3:0] sh;
  logic [15:0] mul_q, asr;
  logic busy, ismul, ok;
  sbi_pkg::rsp_t rsp_q, rsp_d;

  assign op = ir_q[15:12];
  assign d = ir_q[11:9];
  assign s = ir_q[8:6];
  assign t = ir_q[2:0];
  assign sh = ir_q[3:0];
  assign rsv = rf_q[s];
  assign rtv = rf_q[t];
  assign rdv = rf_q[d];
  assign sx5 = {{11{ir_q[4]}}, ir_q[4:0]};
  assign sx6 = {{10{ir_q[5]}}, ir_q[5:0]};
  assign sx7 = {{9{ir_q[6]}}, ir_q[6:0]};
  assign sx9 = {{7{ir_q[8]}}, ir_q[8:0]};
  assign sx11 = {{5{ir_q[10]}}, ir_q[10:0]};
  assign pc1 = pc_q + 16'd1;
  assign ea = rsv + sx6;
  assign asr = 16'($signed(rsv) >>> sh);

  sbi_div u_div (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .dividend_i(rsv), .divisor_i(rtv),
    .busy_o(busy), .quot_o(quot), .rem_o(rem)
  );

  function automatic logic [2:0] cmpf(logic [15:0] a, logic [15:0] b);
    if (a > b) return 3'd1;
    if (a < b) return 3'd4;
    return 3'd2;
  endfunction
  function automatic logic [2:0] flg(logic [15:0] v);
    if (v == 16'd0) return 3'd2;
    return v[15] ? 3'd4 : 3'd1;
  endfunction

  // memory clearing pass after reset
  assign clr_d = clr_q + AddrW'(1);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else if (cmd_i.clear) clr_q <= clr_d;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) mem[clr_q] <= '0;
    else if (cmd_i.mem_load) mem[req_i.load_addr[AddrW-1:0]] <= req_i.load_data;
    else if (cmd_i.commit && dwe_q && st_q == sbi_pkg::StOk)
      mem[addr_q[AddrW-1:0]] <= dval_q;
    if (cmd_i.fetch) ir_q <= mem[pc_q[AddrW-1:0]];
    if (cmd_i.data_rd) rdata_q <= mem[addr_q[AddrW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) mul_q <= 16'(rsv * rtv);
  end

  // execute: decode into registered results
  always_comb begin
    next_d = pc1; val_d = '0; addr_d = '0; dval_d = '0; d_d = d;
    rwe_d = 1'b0; nwe_d = 1'b0; dwe_d = 1'b0; st_d = sbi_pkg::StOk;
    cmpn_d = '0; ismem_d = 1'b0; isdiv_d = 1'b0; ismod_d = 1'b0;
    case (op)
      sbi_pkg::OpBr: if ((d & nzp_q) != 3'd0) next_d = pc1 + sx9;
      sbi_pkg::OpArith: begin
        rwe_d = 1'b1;
        if (ir_q[5]) val_d = rsv + sx5;
        else begin
          case (ir_q[4:3])
            2'd0: val_d = rsv + rtv;
            2'd2: val_d = rsv - rtv;
            2'd3: isdiv_d = 1'b1;
            default: val_d = '0;
          endcase
        end
      end
      sbi_pkg::OpCmp: begin
        nwe_d = 1'b1;
        case (ir_q[8:7])
          2'd0: cmpn_d = cmpf(rdv ^ 16'h8000, rtv ^ 16'h8000);
          2'd1: cmpn_d = cmpf(rdv, rtv);
          2'd2: cmpn_d = cmpf(rdv ^ 16'h8000, sx7 ^ 16'h8000);
          default: cmpn_d = cmpf(rdv, {9'd0, ir_q[6:0]});
        endcase
      end
      sbi_pkg::OpJsr: begin
        rwe_d = 1'b1; val_d = pc1; d_d = 3'd7;
        next_d = ir_q[11] ? ({pc_q[15], 15'd0} | {sx11[11:0], 4'd0}) : rsv;
      end
      sbi_pkg::OpLogic: begin
        rwe_d = 1'b1;
        if (ir_q[5]) val_d = rsv & sx5;
        else begin
          case (ir_q[4:3])
            2'd0: val_d = rsv & rtv;
            2'd1: val_d = ~rsv;
            2'd2: val_d = rsv | rtv;
            default: val_d = rsv ^ rtv;
          endcase
        end
      end
      sbi_pkg::OpLdr, sbi_pkg::OpStr: begin
        addr_d = ea; ismem_d = 1'b1;
        if (ea < 16'h2000 || (ea >= 16'h8000 && ea < 16'hA000))
          st_d = sbi_pkg::StBadAddr;
        else if (ea >= 16'h8000 && !priv_q) st_d = sbi_pkg::StPriv;
        else if (op == sbi_pkg::OpLdr) rwe_d = 1'b1;
        else begin
          dwe_d = 1'b1; dval_d = rdv;
        end
      end
      sbi_pkg::OpRti: next_d = rf_q[7];
      sbi_pkg::OpConst: begin
        rwe_d = 1'b1; val_d = sx9;
      end
      sbi_pkg::OpShift: begin
        rwe_d = 1'b1;
        case (ir_q[5:4])
          2'd0: val_d = rsv << sh;
          2'd1: val_d = asr;
          2'd2: val_d = rsv >> sh;
          default: ismod_d = 1'b1;
        endcase
      end
      sbi_pkg::OpJmp: next_d = ir_q[11] ? pc1 + sx11 : rsv;
      sbi_pkg::OpHiconst: begin
        rwe_d = 1'b1; val_d = {ir_q[7:0], rdv[7:0]};
      end
      sbi_pkg::OpTrap: begin
        rwe_d = 1'b1; val_d = pc1; d_d = 3'd7;
        next_d = {8'h80, ir_q[7:0]};
      end
      default: st_d = sbi_pkg::StIllegal;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      next_q <= next_d; val_q <= val_d; addr_q <= addr_d; dval_q <= dval_d; d_q <= d_d;
      rwe_q <= rwe_d; nwe_q <= nwe_d; dwe_q <= dwe_d; st_q <= st_d;
      cmpn_q <= cmpn_d; ismem_q <= ismem_d; isdiv_q <= isdiv_d; ismod_q <= ismod_d;
    end
  end

  assign ismul = (op == sbi_pkg::OpArith) && !ir_q[5] && ir_q[4:3] == 2'd1;
  always_comb begin
    ldv = val_q;
    if (ismul) ldv = mul_q;
    else if (isdiv_q) ldv = quot;
    else if (ismod_q) ldv = rem;
    else if (op == sbi_pkg::OpLdr) ldv = rdata_q;
  end

  assign ok = (st_q == sbi_pkg::StOk);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= sbi_pkg::PcReset; priv_q <= 1'b1; nzp_q <= sbi_pkg::NzpZero;
      for (int i = 0; i < 8; i++) rf_q[i] <= '0;
    end else if (cmd_i.commit && ok) begin
      pc_q <= next_q;
      if (rwe_q) begin
        rf_q[d_q] <= ldv; nzp_q <= flg(ldv);
      end else if (nwe_q) nzp_q <= cmpn_q;
      if (op == sbi_pkg::OpRti) priv_q <= 1'b0;
      if (op == sbi_pkg::OpTrap) priv_q <= 1'b1;
    end
  end

  always_comb begin
    rsp_d = '0;
    if (cmd_i.mem_load) begin
      rsp_d.dmem_addr = req_i.load_addr; rsp_d.dmem_value = req_i.load_data;
      rsp_d.status = sbi_pkg::StLoaded;
    end else begin
      rsp_d.pc_now = pc_q; rsp_d.instr_word = ir_q; rsp_d.status = st_q;
      rsp_d.dmem_addr = addr_q;
      if (ok) begin
        rsp_d.reg_we = rwe_q;
        rsp_d.reg_dest = rwe_q ? d_q : 3'd0;
        rsp_d.reg_value = rwe_q ? ldv : 16'd0;
        rsp_d.nzp_we = rwe_q | nwe_q;
        rsp_d.nzp_value = rwe_q ? flg(ldv) : (nwe_q ? cmpn_q : 3'd0);
        rsp_d.data_we = dwe_q;
        rsp_d.dmem_value = ismem_q ? (dwe_q ? dval_q : rdata_q) : 16'd0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_load || cmd_i.commit) rsp_q <= rsp_d;
  end
  assign rsp_o = rsp_q;

  assign sts_o.clear_done = &clr_q;
  assign sts_o.is_load = !req_i.cmd;
  assign sts_o.need_div = isdiv_q | ismod_q;
  assign sts_o.div_busy = busy;
  assign sts_o.need_mem = ismem_q && ok && !dwe_q;
endmodule

FILE: design/sbi_ctrl.sv
// controller state machine sequencing fetch, execute, memory and writeback
// depends on sbi_pkg
`timescale 1ns / 1ps
module sbi_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  sbi_pkg::sts_t sts_i,
  output sbi_pkg::cmd_t cmd_o
);
  typedef enum logic [7:0] {
    SClear = 8'b00000001, SIdle = 8'b00000010, SFetch = 8'b00000100,
    SExec = 8'b00001000, SDec = 8'b00010000, SDiv = 8'b00100000,
    SMem = 8'b01000000, SCommit = 8'b10000000
  } state_e;
  state_e state_q, state_d;
  logic ov_q, ov_d, acc, free;

  assign free = !ov_q || !out_stall_i;
  assign in_stall_o = !(state_q == SIdle) || !free;
  assign acc = in_valid_i && !in_stall_o;
  assign out_valid_o = ov_q;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    ov_d = ov_q && out_stall_i;
    case (state_q)
      SClear: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_done) state_d = SIdle;
      end
      SIdle: if (acc) begin
        if (sts_i.is_load) begin
          cmd_o.mem_load = 1'b1; ov_d = 1'b1;
        end else state_d = SFetch;
      end
      SFetch: begin
        cmd_o.fetch = 1'b1; state_d = SExec;
      end
      SExec: begin
        cmd_o.exec = 1'b1; state_d = SDec;
      end
      SDec: begin
        if (sts_i.need_div) begin
          cmd_o.div_start = 1'b1; state_d = SDiv;
        end else if (sts_i.need_mem) begin
          cmd_o.data_rd = 1'b1; state_d = SMem;
        end else state_d = SCommit;
      end
      SDiv: if (!sts_i.div_busy) state_d = SCommit;
      SMem: state_d = SCommit;
      SCommit: if (free) begin
        cmd_o.commit = 1'b1; ov_d = 1'b1; state_d = SIdle;
      end
      default: state_d = SClear;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear; ov_q <= 1'b0;
    end else begin
      state_q <= state_d; ov_q <= ov_d;
    end
  end
endmodule

FILE: design/sixteen_bit_isa_instruction_step.sv
// After reset the memory is cleared, one word per cycle, and requests stall until
// that pass ends. An execute request then passes through accept, fetch, execute,
// decode and commit, plus a memory read state for a load word and a divide wait
// state for divide or mod, where the one-bit-per-cycle divider holds it. A memory-load
// request writes memory when it is accepted. All work goes through one memory port
// per cycle. The result is held in an output register so the next request is taken
// as soon as that register is free. Depends on sbi_pkg, sbi_ctrl, sbi_datapath.
`timescale 1ns / 1ps
`include "sixteen_bit_isa_instruction_step_macros.svh"
module sixteen_bit_isa_instruction_step #(
  parameter int MEM_WORDS = 65536
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  sbi_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output sbi_pkg::rsp_t out_data_o
);
  sbi_pkg::cmd_t cmd;
  sbi_pkg::sts_t sts;

  sbi_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );
  sbi_datapath #(.AddrW($clog2(MEM_WORDS))) u_dp (
    .clk_i, .rst_ni, .req_i(in_data_i), .cmd_i(cmd), .sts_o(sts), .rsp_o(out_data_o)
  );

  `SBI_ASSERT_IMP(a_one_cmd, clk_i, rst_ni, 1'b1, $onehot0(cmd))
  `SBI_ASSERT_NEXT(a_commit_valid, clk_i, rst_ni, cmd.commit, out_valid_o)
  `SBI_ASSERT_IMP(a_no_overwrite, clk_i, rst_ni, out_valid_o && out_stall_i,
    !cmd.commit && !cmd.mem_load)
endmodule
